// ----- src/smcol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcol_pkg
// Shared constants, types and the exp table for the softmax column block.
// ----------------------------------------------------------------------------
package smcol_pkg;

	localparam int MAX_ROWS  = 32;
	localparam int EXP_DEPTH = 256;

	localparam int DATA_W = 16;
	localparam int PROB_W = 17;
	localparam int AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W  = $clog2(MAX_ROWS + 1);
	localparam int EIW    = $clog2(EXP_DEPTH);
	localparam int SUM_W  = PROB_W + $clog2(MAX_ROWS);
	localparam int NUM_W  = SUM_W + PROB_W;
	localparam int DOT_W  = 2 * DATA_W + $clog2(MAX_ROWS) + 1;
	localparam int DIFF_W = DOT_W + 1;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;
	localparam logic [1:0] ST_MIX = 2'd3;

	typedef struct packed {
		logic             go;
		logic [NUM_W-1:0] num;
		logic [SUM_W-1:0] den;
	} div_req_t;

	typedef logic [PROB_W-1:0] exp_tab_t [EXP_DEPTH];

	// Shift-and-subtract quotient, used only while building the table.
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry k holds exp(-16k/EXP_DEPTH) in Q1.16, built from a Q32 series.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t          tab;
		longint unsigned   a;
		longint unsigned   whole;
		longint unsigned   frac;
		longint unsigned   term;
		longint            acc;
		longint unsigned   v;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			a     = (longint'(k) << 36) / EXP_DEPTH;
			whole = a >> 32;
			frac  = a & 64'hFFFF_FFFF;
			term  = 64'h1_0000_0000;
			acc   = 0;
			for (int i = 0; i < 25; i++) begin
				if (i % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
				term = udiv64((term * frac) >> 32, longint'(i + 1));
			end
			v = longint'(acc);
			for (int j = 0; j < 16; j++) begin
				if (longint'(j) < whole) begin
					v = (v * 64'd1580030169) >> 32;
				end
			end
			tab[k] = PROB_W'((v + 64'd32768) >> 16);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ----- src/smcol_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcol_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smcol_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/smcol_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcol_div
// Restoring divider, one quotient bit per cycle, for the probability pass.
// ----------------------------------------------------------------------------
module smcol_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smcol_pkg::div_req_t      req,
	output logic                     done,
	output logic [smcol_pkg::PROB_W-1:0] quot
);

	localparam int QW  = smcol_pkg::PROB_W;
	localparam int SW  = smcol_pkg::SUM_W;
	localparam int CW  = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [QW-1:0] q_q;
	logic [SW-1:0] den_q;
	logic [SW:0]   r2;
	logic          ge;

	assign r2 = {rem_q, low_q[QW-1]};
	assign ge = (r2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient is known to fit in QW bits, so the top of the numerator
	// starts out below the divisor.
	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.num[smcol_pkg::NUM_W-1:QW];
			low_q <= req.num[QW-1:0];
			den_q <= req.den;
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= SW'(r2 - {1'b0, den_q});
			end else begin
				rem_q <= r2[SW-1:0];
			end
			q_q   <= {q_q[QW-2:0], ge};
			low_q <= {low_q[QW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quot = q_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider finished without running");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CW'(1) |-> !req.go)
		else $error("divider restarted while busy");

endmodule

// ----- src/softmax_column_fwd_bwd_top.sv -----
`timescale 1ns / 1ps
// Each word is taken while start is high in idle; the column is processed after the word with last.
// Forward: a max pass and an exp pass over the rows, then one divider run per probability,
// and the divider makes one quotient bit per cycle. Backward: a dot-product pass, then each
// gradient goes through the split multiplier. Error results come in the cycle after last.
// busy stays high while a column is processed; results are never stalled.
// Reset clears all control state; the RAMs need no clearing.
// ----------------------------------------------------------------------------
// softmax_column_fwd_bwd_top
// Column softmax with forward probabilities and backward gradients.
// ----------------------------------------------------------------------------
module softmax_column_fwd_bwd_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic signed [15:0] value,
	input  logic               last,
	output logic               strobe,
	output logic               result_kind,
	output logic signed [17:0] result_value,
	output logic [4:0]         row_index,
	output logic               result_last,
	output logic [1:0]         status
);

	localparam int AW     = smcol_pkg::AW;
	localparam int CW     = smcol_pkg::CNT_W;
	localparam int DW     = smcol_pkg::DATA_W;
	localparam int PW     = smcol_pkg::PROB_W;
	localparam int SW     = smcol_pkg::SUM_W;
	localparam int DOTW   = smcol_pkg::DOT_W;
	localparam int DIFW   = smcol_pkg::DIFF_W;
	localparam int HIW    = DIFW - 24;
	localparam int RW     = DIFW + 19;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MAX  = 11'b00000000010,
		S_EXP  = 11'b00000000100,
		S_DRD  = 11'b00000001000,
		S_DLD  = 11'b00000010000,
		S_DRUN = 11'b00000100000,
		S_DOT  = 11'b00001000000,
		S_GRD  = 11'b00010000000,
		S_GLD  = 11'b00100000000,
		S_GMUL = 11'b01000000000,
		S_GOUT = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [CW-1:0] cnt_q, n_q, plen_q, idx_q;
	logic          ck_q, mix_q, ovf_q, ovf_st_q, pvalid_q;

	logic          v_s1, last_s1, v_s2, last_s2;
	logic [AW-1:0] addr_s1;

	logic signed [DW-1:0]   mx_q;
	logic [SW-1:0]          sum_q;
	logic signed [33:0]     prod_s2;
	logic signed [DOTW-1:0] dot_q;
	logic signed [DIFW-1:0] diff_q;
	logic [PW-1:0]          p_q;
	logic [PW+23:0]         lo_q;
	logic signed [HIW+17:0] hi_q;

	logic               strobe_q, rkind_q, rlast_q;
	logic signed [17:0] rval_q;
	logic [4:0]         rrow_q;
	logic [1:0]         rstat_q;

	// Load side.
	logic          accept;
	logic          ck_n, mix_n, ovf_n, room;
	logic [CW-1:0] cnt_n;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign room   = (cnt_q < CW'(smcol_pkg::MAX_ROWS));
	assign ck_n   = (cnt_q == '0) ? kind : ck_q;
	assign mix_n  = mix_q || ((cnt_q != '0) && (kind != ck_q));
	assign ovf_n  = ovf_q || !room;
	assign cnt_n  = room ? cnt_q + CW'(1) : cnt_q;

	// RAMs.
	logic            d_we, p_we;
	logic [AW-1:0]   p_waddr;
	logic [PW-1:0]   p_wdata;
	logic [DW-1:0]   d_rdata;
	logic [PW-1:0]   p_rdata;

	smcol_ram #(.WIDTH(DW), .DEPTH(smcol_pkg::MAX_ROWS)) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (value),
		.raddr (idx_q[AW-1:0]),
		.rdata (d_rdata)
	);

	smcol_ram #(.WIDTH(PW), .DEPTH(smcol_pkg::MAX_ROWS)) u_prob_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (p_rdata)
	);

	assign d_we = accept && room;

	// Exp lookup on the shifted sample.
	logic signed [DW:0] sdiff;
	logic [DW-1:0]      neg;
	logic [31:0]        tidx;
	logic [PW-1:0]      e_val;

	assign sdiff = {mx_q[DW-1], mx_q} - {d_rdata[DW-1], d_rdata};
	assign neg   = sdiff[DW-1:0];
	assign tidx  = ({16'b0, neg} * 32'(smcol_pkg::EXP_DEPTH)) >> 16;
	assign e_val = (tidx < 32'(smcol_pkg::EXP_DEPTH)) ?
		smcol_pkg::EXP_TAB[tidx[smcol_pkg::EIW-1:0]] : '0;

	// Divider.
	smcol_pkg::div_req_t div_req;
	logic                div_done;
	logic [PW-1:0]       div_quot;
	logic [PW-1:0]       p_final;

	assign div_req.go  = (state_q == S_DLD);
	assign div_req.num = {p_rdata, 16'b0} + smcol_pkg::NUM_W'(sum_q >> 1);
	assign div_req.den = sum_q;
	assign p_final     = (div_quot > PW'(65536)) ? PW'(65536) : div_quot;

	smcol_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		p_we    = 1'b0;
		p_waddr = addr_s1;
		p_wdata = e_val;
		if (state_q == S_EXP && v_s1) begin
			p_we = 1'b1;
		end else if (state_q == S_DRUN && div_done) begin
			p_we    = 1'b1;
			p_waddr = idx_q[AW-1:0];
			p_wdata = p_final;
		end
	end

	// Gradient arithmetic.
	logic signed [33:0]     prod;
	logic signed [RW-1:0]   hi_ext, lo_ext, rsum, rsh;
	logic signed [17:0]     gsat;
	logic                   issue, at_last;

	assign prod   = $signed(d_rdata) * $signed({1'b0, p_rdata});
	assign hi_ext = RW'(hi_q);
	assign lo_ext = RW'($signed({1'b0, lo_q}));
	assign rsum   = (hi_ext <<< 24) + lo_ext + (RW'(1) <<< 31);
	assign rsh    = rsum >>> 32;
	always_comb begin
		if (rsh > 32767) begin
			gsat = 18'sd32767;
		end else if (rsh < -32768) begin
			gsat = -18'sd32768;
		end else begin
			gsat = 18'(rsh);
		end
	end

	assign issue   = (idx_q != n_q) &&
		(state_q == S_MAX || state_q == S_EXP || state_q == S_DOT);
	assign at_last = (idx_q == n_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			n_q      <= '0;
			plen_q   <= '0;
			idx_q    <= '0;
			ck_q     <= 1'b0;
			mix_q    <= 1'b0;
			ovf_q    <= 1'b0;
			ovf_st_q <= 1'b0;
			pvalid_q <= 1'b0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			v_s1     <= issue;
			last_s1  <= issue && at_last;
			v_s2     <= v_s1 && (state_q == S_DOT);
			last_s2  <= last_s1 && (state_q == S_DOT);
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ck_q  <= ck_n;
						mix_q <= mix_n;
						ovf_q <= ovf_n;
						cnt_q <= cnt_n;
						if (last) begin
							cnt_q    <= '0;
							mix_q    <= 1'b0;
							ovf_q    <= 1'b0;
							n_q      <= cnt_n;
							ovf_st_q <= ovf_n;
							idx_q    <= '0;
							if (mix_n) begin
								strobe_q <= 1'b1;
							end else if (!ck_n) begin
								state_q <= S_MAX;
							end else if (!pvalid_q || cnt_n != plen_q) begin
								strobe_q <= 1'b1;
							end else begin
								state_q <= S_DOT;
							end
						end
					end
				end
				S_MAX: begin
					if (last_s1) begin
						state_q <= S_EXP;
						idx_q   <= '0;
					end
				end
				S_EXP: begin
					if (last_s1) begin
						state_q <= S_DRD;
						idx_q   <= '0;
					end
				end
				S_DRD:  state_q <= S_DLD;
				S_DLD:  state_q <= S_DRUN;
				S_DRUN: begin
					if (div_done) begin
						strobe_q <= 1'b1;
						if (at_last) begin
							state_q  <= S_IDLE;
							pvalid_q <= 1'b1;
							plen_q   <= n_q;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_DRD;
						end
					end
				end
				S_DOT: begin
					if (last_s2) begin
						state_q <= S_GRD;
						idx_q   <= '0;
					end
				end
				S_GRD:  state_q <= S_GLD;
				S_GLD:  state_q <= S_GMUL;
				S_GMUL: state_q <= S_GOUT;
				S_GOUT: begin
					strobe_q <= 1'b1;
					if (at_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_GRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q[AW-1:0];
		prod_s2 <= prod;
		if (state_q == S_IDLE && accept && last) begin
			sum_q   <= '0;
			dot_q   <= '0;
			rkind_q <= ck_n;
			rval_q  <= '0;
			rrow_q  <= '0;
			rlast_q <= 1'b1;
			rstat_q <= mix_n ? smcol_pkg::ST_MIX : smcol_pkg::ST_LEN;
		end
		if (state_q == S_MAX && v_s1) begin
			if (addr_s1 == '0 || $signed(d_rdata) > mx_q) begin
				mx_q <= $signed(d_rdata);
			end
		end
		if (state_q == S_EXP && v_s1) begin
			sum_q <= sum_q + SW'(e_val);
		end
		if (v_s2) begin
			dot_q <= dot_q + DOTW'(prod_s2);
		end
		if (state_q == S_GLD) begin
			diff_q <= (DIFW'($signed(d_rdata)) <<< 16) - DIFW'(dot_q);
			p_q    <= p_rdata;
		end
		if (state_q == S_GMUL) begin
			lo_q <= p_q * diff_q[23:0];
			hi_q <= $signed({1'b0, p_q}) * $signed(diff_q[DIFW-1:24]);
		end
		if ((state_q == S_DRUN && div_done) || state_q == S_GOUT) begin
			rkind_q <= (state_q == S_GOUT);
			rval_q  <= (state_q == S_GOUT) ? gsat : $signed({1'b0, p_final});
			rrow_q  <= 5'(idx_q[AW-1:0]);
			rlast_q <= at_last;
			rstat_q <= ovf_st_q ? smcol_pkg::ST_OVF : smcol_pkg::ST_OK;
		end
	end

	assign strobe       = strobe_q;
	assign result_kind  = rkind_q;
	assign result_value = rval_q;
	assign row_index    = rrow_q;
	assign result_last  = rlast_q;
	assign status       = rstat_q;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == smcol_pkg::ST_MIX || status == smcol_pkg::ST_LEN)
		|-> result_last && result_value == 18'sd0)
		else $error("error word is not a single final word");

	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result_kind |-> result_value >= 0 && result_value <= 65536)
		else $error("probability out of range");

	a_grad_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind |-> result_value >= -32768 && result_value <= 32767)
		else $error("gradient not saturated");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_last |-> !busy)
		else $error("final word while column still in work");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives columns of forward samples and backward gradients into the softmax
// column block, predicts every probability, gradient and error word, and
// compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic               kind;
		logic signed [17:0] val;
		logic [4:0]         row;
		logic               lst;
		logic [1:0]         st;
	} softmax_word_t;

	class softmax_scoreboard;
		softmax_word_t  pending[$];
		int             errors;
		longint         exp_lut[smcol_pkg::EXP_DEPTH];
		int             samples[smcol_pkg::MAX_ROWS];
		longint         probs[smcol_pkg::MAX_ROWS];
		int             grads[smcol_pkg::MAX_ROWS];
		int             count;
		int             plen;
		bit             pvalid;
		bit             ckind;
		bit             ovf;
		bit             mixed;

		function new();
			longint unsigned pos, frac, term, v;
			longint          acc;
			int              whole;
			for (int k = 0; k < smcol_pkg::EXP_DEPTH; k++) begin
				pos   = (longint'(k) << 36) / smcol_pkg::EXP_DEPTH;
				whole = int'(pos >> 32);
				frac  = pos & 64'hFFFF_FFFF;
				term  = 64'h1_0000_0000;
				acc   = 0;
				for (int n = 0; n < 25; n++) begin
					acc  = (n % 2) ? acc - longint'(term) : acc + longint'(term);
					term = ((term * frac) >> 32) / (n + 1);
				end
				v = acc;
				repeat (whole) v = (v * 64'd1580030169) >> 32;
				exp_lut[k] = longint'((v + 64'd32768) >> 16);
			end
			errors = 0;
			count  = 0;
			plen   = 0;
			pvalid = 0;
			ckind  = 0;
			ovf    = 0;
			mixed  = 0;
		endfunction

		function void push(logic k, longint v, int r, bit l, logic [1:0] s);
			softmax_word_t w;
			w.kind = k;
			w.val  = 18'(v);
			w.row  = 5'(r);
			w.lst  = l;
			w.st   = s;
			pending.push_back(w);
		endfunction

		function void note_word(logic k, logic signed [15:0] v, logic l);
			int         mx, n;
			longint     e[smcol_pkg::MAX_ROWS];
			longint     sum, p, dot, diff, r;
			logic [1:0] st;
			if (count == 0 && !ovf) begin
				ckind = k;
			end else if (k != ckind) begin
				mixed = 1;
			end
			if (count < smcol_pkg::MAX_ROWS) begin
				if (k) begin
					grads[count] = v;
				end else begin
					samples[count] = v;
				end
				count++;
			end else begin
				ovf = 1;
			end
			if (!l) return;
			n     = count;
			st    = ovf ? smcol_pkg::ST_OVF : smcol_pkg::ST_OK;
			count = 0;
			ovf   = 0;
			if (mixed) begin
				mixed = 0;
				push(ckind, 0, 0, 1, smcol_pkg::ST_MIX);
				return;
			end
			if (!ckind) begin
				mx = samples[0];
				for (int i = 1; i < n; i++) if (samples[i] > mx) mx = samples[i];
				sum = 0;
				for (int i = 0; i < n; i++) begin
					// The shift is at most 65535, so the index always lands in the table.
					e[i] = exp_lut[((mx - samples[i]) * smcol_pkg::EXP_DEPTH) >>> 16];
					sum += e[i];
				end
				if (sum == 0) sum = 1;
				for (int i = 0; i < n; i++) begin
					p = (e[i] * 65536 + sum / 2) / sum;
					if (p > 65536) p = 65536;
					probs[i] = p;
					push(0, p, i, i + 1 == n, st);
				end
				plen   = n;
				pvalid = 1;
				return;
			end
			if (!pvalid || n != plen) begin
				push(1, 0, 0, 1, smcol_pkg::ST_LEN);
				return;
			end
			dot = 0;
			for (int i = 0; i < n; i++) dot += longint'(grads[i]) * probs[i];
			for (int i = 0; i < n; i++) begin
				diff = longint'(grads[i]) * 65536 - dot;
				r    = (probs[i] * diff + (longint'(1) << 31)) >>> 32;
				if (r > 32767) r = 32767;
				if (r < -32768) r = -32768;
				push(1, r, i, i + 1 == n, st);
			end
		endfunction

		function void check_word(softmax_word_t got);
			softmax_word_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word kind=%0d value=%0d row=%0d", $time,
					got.kind, got.val, got.row);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.kind !== w.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, w.kind, got.kind);
				errors++;
			end
			if (got.val !== w.val) begin
				$display("%0t: value expected %0d actual %0d", $time, w.val, got.val);
				errors++;
			end
			if (got.row !== w.row) begin
				$display("%0t: row expected %0d actual %0d", $time, w.row, got.row);
				errors++;
			end
			if (got.lst !== w.lst) begin
				$display("%0t: last expected %0d actual %0d", $time, w.lst, got.lst);
				errors++;
			end
			if (got.st !== w.st) begin
				$display("%0t: status expected %0d actual %0d", $time, w.st, got.st);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               kind;
	logic signed [15:0] value;
	logic               last;
	logic               strobe;
	logic               result_kind;
	logic signed [17:0] result_value;
	logic [4:0]         row_index;
	logic               result_last;
	logic [1:0]         status;

	softmax_column_fwd_bwd_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.value(value), .last(last), .strobe(strobe), .result_kind(result_kind),
		.result_value(result_value), .row_index(row_index),
		.result_last(result_last), .status(status)
	);

	softmax_scoreboard sb = new();
	int                idle_pct;
	int                quiet_cycles = 0;
	logic              fwd_kind;
	logic              bwd_kind;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Inputs are sampled before the edge updates them, so accept and result
	// words are both seen with their pre-edge values here.
	always @(posedge clk) begin
		softmax_word_t got;
		quiet_cycles <= quiet_cycles + 1;
		if (arst_n && start && !busy) begin
			sb.note_word(kind, value, last);
			quiet_cycles <= 0;
		end
		if (arst_n && strobe) begin
			got.kind = result_kind;
			got.val  = result_value;
			got.row  = row_index;
			got.lst  = result_last;
			got.st   = status;
			sb.check_word(got);
			quiet_cycles <= 0;
		end
		if (quiet_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [15:0] pick_value(int spread);
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	task automatic send_word(logic k, logic signed [15:0] v, logic l);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1;
		kind  <= k;
		value <= v;
		last  <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// A column of n words; mix_at names a word that carries the other kind.
	task automatic send_column(logic k, int n, int mix_at, int spread);
		for (int i = 0; i < n; i++) begin
			send_word((i == mix_at) ? ~k : k, pick_value(spread), i == n - 1);
		end
	endtask

	task automatic random_phase(int items);
		int sent, n, pick, nb;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 19);
			n    = (pick == 0) ? $urandom_range(33, 35) : $urandom_range(1, 8);
			send_column(fwd_kind, n, (pick == 1) ? $urandom_range(0, n - 1) : -1,
				$urandom_range(0, 1) ? 4096 : 32768);
			sent += n;
			if (n > smcol_pkg::MAX_ROWS) n = smcol_pkg::MAX_ROWS;
			repeat ($urandom_range(1, 2)) begin
				pick = $urandom_range(0, 9);
				nb   = (pick == 0) ? n + 1 : n;
				send_column(bwd_kind, nb, (pick == 1) ? $urandom_range(0, nb - 1) : -1,
					32768);
				sent += nb;
			end
		end
	endtask

	initial begin
		fwd_kind     = 0;
		bwd_kind     = 1;
		idle_pct     = 0;
		arst_n       = 0;
		start        = 0;
		kind         = 0;
		value        = 0;
		last         = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Backward with no probabilities held yet.
		send_word(bwd_kind, 16'sh1000, 1);
		send_word(fwd_kind, -16'sh8000, 1);
		send_word(bwd_kind, 16'sh7FFF, 1);
		// Extremes: the minimum lies 65535 below the maximum, the widest shift.
		send_word(fwd_kind, 16'sh7FFF, 0);
		send_word(fwd_kind, -16'sh8000, 0);
		send_word(fwd_kind, 16'sh0000, 1);
		send_word(bwd_kind, -16'sh8000, 0);
		send_word(bwd_kind, 16'sh7FFF, 0);
		send_word(bwd_kind, 16'sh0001, 1);
		// Repeated backward on the same probabilities.
		send_word(bwd_kind, 16'sh7FFF, 0);
		send_word(bwd_kind, 16'sh7FFF, 0);
		send_word(bwd_kind, -16'sh8000, 1);
		// Length mismatch, then mixed kinds in both directions.
		send_word(bwd_kind, 16'sh0100, 0);
		send_word(bwd_kind, 16'sh0100, 1);
		send_word(fwd_kind, 16'sh0100, 0);
		send_word(bwd_kind, 16'sh0100, 1);
		send_word(bwd_kind, 16'sh0100, 0);
		send_word(fwd_kind, 16'sh0100, 1);
		// Equal samples give equal probabilities.
		send_word(fwd_kind, 16'sh1234, 0);
		send_word(fwd_kind, 16'sh1234, 0);
		send_word(fwd_kind, 16'sh1234, 1);

		idle_pct = 37;
		random_phase(80);
		idle_pct = 48;
		random_phase(80);
		idle_pct = 0;
		random_phase(80);
		start <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
